// File: hdl/dense_matrix_row_multiply_assert.svh
// Assertion macros for the dense matrix row multiply checker.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef DENSE_MATRIX_ROW_MULTIPLY_ASSERT_SVH
`define DENSE_MATRIX_ROW_MULTIPLY_ASSERT_SVH

// checked only while out of reset
`define DMRM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define DMRM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: hdl/dmrm_pkg.sv
// Shared constants, types and helpers of the dense matrix row multiply block.
// No dependencies.
package dmrm_pkg;

    localparam int MAX_N      = 32;
    localparam int IDX_W      = 5;
    localparam int N_W        = $clog2(MAX_N + 1);
    localparam int ELEM_BITS  = 16;
    localparam int ACC_BITS   = 37;
    localparam int PROD_W     = 2 * ELEM_BITS;
    localparam int B_DEPTH    = MAX_N * MAX_N;
    localparam int B_ADDR_W   = $clog2(B_DEPTH);
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam int S_TDATA_W  = ((2 * IDX_W + ELEM_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((2 * IDX_W + ACC_BITS + 7) / 8) * 8;

    localparam int SIZE_W     = 6;
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(32);
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int REG_IDX_W  = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_IN_USE = REG_IDX_W'(0);

    localparam logic ACT_LOAD_B = 1'b0;
    localparam logic ACT_A_ELEM = 1'b1;

    typedef struct packed {
        logic                        is_a;
        logic                        is_last;
        logic [IDX_W-1:0]            row;
        logic [IDX_W-1:0]            col;
        logic signed [ELEM_BITS-1:0] value;
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    function automatic logic [B_ADDR_W-1:0] b_addr(input logic [IDX_W-1:0] row,
                                                    input logic [IDX_W-1:0] col);
        b_addr = B_ADDR_W'(int'(row) * MAX_N + int'(col));
    endfunction

endpackage

// File: hdl/dmrm_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module dmrm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/dmrm_front.sv
// Front end: accepts input requests, drops out-of-range ones, queues the rest.
// Depends on dmrm_pkg.
module dmrm_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [dmrm_pkg::N_W-1:0]       i_n_eff,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [dmrm_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                           i_s_tuser,
    output dmrm_pkg::t_op                  o_op,
    output logic                           o_op_valid,
    input  logic                           i_op_ready
);

    localparam int IW = dmrm_pkg::IDX_W;
    localparam int EW = dmrm_pkg::ELEM_BITS;

    dmrm_pkg::t_op                     r_q [dmrm_pkg::FIFO_DEPTH];
    logic [dmrm_pkg::FIFO_AW-1:0]      r_wptr;
    logic [dmrm_pkg::FIFO_AW-1:0]      r_rptr;
    logic [dmrm_pkg::FIFO_CW-1:0]      r_count;

    logic [IW-1:0] row;
    logic [IW-1:0] col;
    logic          keep;
    logic          push;
    logic          pop;
    dmrm_pkg::t_op op_in;

    assign row = i_s_tdata[IW-1:0];
    assign col = i_s_tdata[2*IW-1:IW];

    always_comb begin
        op_in.is_a    = (i_s_tuser == dmrm_pkg::ACT_A_ELEM);
        op_in.is_last = (col == IW'(i_n_eff - 1'b1));
        op_in.row     = row;
        op_in.col     = col;
        op_in.value   = i_s_tdata[2*IW+EW-1:2*IW];
        if (op_in.is_a) begin
            keep = (dmrm_pkg::N_W'(row) < i_n_eff) && (dmrm_pkg::N_W'(col) < i_n_eff);
        end else begin
            keep = (int'(row) < dmrm_pkg::MAX_N) && (int'(col) < dmrm_pkg::MAX_N);
        end
    end

    assign o_s_tready = (r_count != dmrm_pkg::FIFO_CW'(dmrm_pkg::FIFO_DEPTH));
    assign o_op_valid = (r_count != '0);
    assign o_op       = r_q[r_rptr];
    assign push       = i_s_tvalid && o_s_tready && keep;
    assign pop        = o_op_valid && i_op_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= op_in;
        end
    end

endmodule

// File: hdl/dmrm_back.sv
// Back end: B store writes, shared multiply-accumulate over columns, row emission.
// Depends on dmrm_pkg and dmrm_ram.
module dmrm_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [dmrm_pkg::N_W-1:0]       i_n_eff,
    input  dmrm_pkg::t_op                  i_op,
    input  logic                           i_op_valid,
    output logic                           o_op_ready,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [dmrm_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic                           o_m_tlast
);

    localparam int IW = dmrm_pkg::IDX_W;
    localparam int EW = dmrm_pkg::ELEM_BITS;
    localparam int AW = dmrm_pkg::ACC_BITS;

    dmrm_pkg::t_state r_state, n_state;
    logic [IW-1:0]    r_j, n_j;
    logic signed [EW-1:0] r_a;
    logic [IW-1:0]    r_k;
    logic [IW-1:0]    r_row;
    logic             r_is_last;

    logic             r_p1_valid;
    logic [IW-1:0]    r_p1_j;
    logic             r_p2_valid;
    logic [IW-1:0]    r_p2_j;
    logic signed [dmrm_pkg::PROD_W-1:0] r_prod;

    logic [AW-1:0]    r_acc [dmrm_pkg::MAX_N];

    logic             r_out_valid;
    logic [IW-1:0]    r_out_row;
    logic [IW-1:0]    r_out_col;
    logic [AW-1:0]    r_out_sum;
    logic             r_out_last;

    logic [IW-1:0]    last_j;
    logic             ram_we;
    logic [dmrm_pkg::B_ADDR_W-1:0] ram_waddr;
    logic [dmrm_pkg::B_ADDR_W-1:0] ram_raddr;
    logic [EW-1:0]    ram_rdata;
    logic signed [EW-1:0] b_elem;
    logic             load_op;
    logic             issue;
    logic             emit;

    assign last_j = IW'(i_n_eff - 1'b1);
    assign b_elem = ram_rdata;

    dmrm_ram #(
        .WIDTH (EW),
        .DEPTH (dmrm_pkg::B_DEPTH)
    ) u_b_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_op.value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_j        = r_j;
        ram_we     = 1'b0;
        ram_waddr  = dmrm_pkg::b_addr(i_op.row, i_op.col);
        ram_raddr  = dmrm_pkg::b_addr(r_k, r_j);
        o_op_ready = 1'b0;
        load_op    = 1'b0;
        issue      = 1'b0;
        emit       = 1'b0;
        unique case (r_state)
            dmrm_pkg::ST_IDLE: begin
                o_op_ready = 1'b1;
                if (i_op_valid) begin
                    if (i_op.is_a) begin
                        load_op = 1'b1;
                        n_j     = '0;
                        n_state = dmrm_pkg::ST_MAC;
                    end else begin
                        ram_we = 1'b1;
                    end
                end
            end
            dmrm_pkg::ST_MAC: begin
                issue = 1'b1;
                if (r_j == last_j) begin
                    n_state = dmrm_pkg::ST_DRAIN;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            dmrm_pkg::ST_DRAIN: begin
                if (!r_p1_valid && !r_p2_valid) begin
                    n_j     = '0;
                    n_state = r_is_last ? dmrm_pkg::ST_EMIT : dmrm_pkg::ST_IDLE;
                end
            end
            dmrm_pkg::ST_EMIT: begin
                if (!r_out_valid || i_m_tready) begin
                    emit = 1'b1;
                    if (r_j == last_j) begin
                        n_state = dmrm_pkg::ST_IDLE;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end
            end
            default: n_state = dmrm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dmrm_pkg::ST_IDLE;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_p1_valid <= issue;
            r_p2_valid <= r_p1_valid;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_j    <= n_j;
        r_p1_j <= r_j;
        r_p2_j <= r_p1_j;
        r_prod <= r_a * b_elem;
        if (load_op) begin
            r_a       <= i_op.value;
            r_k       <= i_op.col;
            r_row     <= i_op.row;
            r_is_last <= i_op.is_last;
        end
        if (emit) begin
            r_out_row  <= r_row;
            r_out_col  <= r_j;
            r_out_sum  <= r_acc[r_j];
            r_out_last <= (r_j == last_j);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < dmrm_pkg::MAX_N; i++) begin
                r_acc[i] <= '0;
            end
        end else if (r_p2_valid) begin
            r_acc[r_p2_j] <= r_acc[r_p2_j] + AW'(r_prod);
        end else if (emit) begin
            r_acc[r_j] <= '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = dmrm_pkg::M_TDATA_W'({r_out_sum, r_out_col, r_out_row});

endmodule

// File: hdl/dense_matrix_row_multiply.sv
// Dense square matrix multiply C = A x B, one row of C at a time.
// Top level: APB register, front end queue and back end datapath.
// Depends on dmrm_pkg, dmrm_front, dmrm_back.
//
// Load B first with action 0 requests (written to the B store while the back end
// is idle), then stream the A elements of a row with action 1. Each A element
// runs one shared multiply-accumulate over the n columns, reading B from a
// single-port-read RAM one column per cycle. The element with k = n-1 then emits
// the row, n results with tlast on the last column, one per cycle while the sink
// is ready. A two-entry queue separates input acceptance from the datapath, so
// requests are taken while a row computes or drains. Out of range elements are
// accepted and dropped. size_in_use must be written only while the block is
// idle; the block itself does not enforce this.
module dense_matrix_row_multiply (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // APB register port
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [dmrm_pkg::PADDR_W-1:0]    i_paddr,
    input  logic [dmrm_pkg::PDATA_W-1:0]    i_pwdata,
    output logic [dmrm_pkg::PDATA_W-1:0]    o_prdata,
    output logic                            o_pready,
    // input stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // tdata: row_index[4:0], col_index[9:5], value[25:10], zero pad
    input  logic [dmrm_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // tuser: action
    input  logic                            i_s_tuser,
    // result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // tdata: out_row[4:0], out_col[9:5], product_sum[46:10], zero pad
    output logic [dmrm_pkg::M_TDATA_W-1:0]  o_m_tdata,
    // tlast: last
    output logic                            o_m_tlast
);

    logic [dmrm_pkg::SIZE_W-1:0] r_size;
    logic [dmrm_pkg::N_W-1:0]    n_eff;
    logic                        sel_size;
    dmrm_pkg::t_op               op;
    logic                        op_valid;
    logic                        op_ready;

    assign sel_size = (i_paddr[dmrm_pkg::PADDR_W-1:2] == dmrm_pkg::REG_SIZE_IN_USE);
    assign o_pready = 1'b1;
    assign o_prdata = sel_size ? dmrm_pkg::PDATA_W'(r_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= dmrm_pkg::SIZE_RESET;
        end else if (i_psel && i_penable && i_pwrite && o_pready && sel_size) begin
            r_size <= i_pwdata[dmrm_pkg::SIZE_W-1:0];
        end
    end

    always_comb begin
        if (r_size == '0) begin
            n_eff = dmrm_pkg::N_W'(1);
        end else if (int'(r_size) > dmrm_pkg::MAX_N) begin
            n_eff = dmrm_pkg::N_W'(dmrm_pkg::MAX_N);
        end else begin
            n_eff = dmrm_pkg::N_W'(r_size);
        end
    end

    dmrm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_n_eff    (n_eff),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_op       (op),
        .o_op_valid (op_valid),
        .i_op_ready (op_ready)
    );

    dmrm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_n_eff    (n_eff),
        .i_op       (op),
        .i_op_valid (op_valid),
        .o_op_ready (op_ready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// File: hdl/dmrm_checker.sv
// Port-level checker for dense_matrix_row_multiply, attached by bind.
// Depends on dmrm_pkg and dense_matrix_row_multiply_assert.svh.
`include "dense_matrix_row_multiply_assert.svh"

module dmrm_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [dmrm_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input  logic                            o_m_tlast
);

    localparam int IW = dmrm_pkg::IDX_W;

    // no result straight out of reset
    `DMRM_ASSERT_ALWAYS(a_no_out_after_reset, !i_rst_n |=> !o_m_tvalid, "result valid after reset")

    `DMRM_ASSERT(a_out_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast), "stalled result changed")

    // back-to-back beats within a row step the column, keep the row
    `DMRM_ASSERT(a_col_step, (o_m_tvalid && i_m_tready && !o_m_tlast) ##1 o_m_tvalid |-> (o_m_tdata[2*IW-1:IW] == $past(o_m_tdata[2*IW-1:IW]) + 1'b1) && (o_m_tdata[IW-1:0] == $past(o_m_tdata[IW-1:0])), "column sequence broken")

    `DMRM_ASSERT(a_row_start, (o_m_tvalid && i_m_tready && o_m_tlast) ##1 o_m_tvalid |-> o_m_tdata[2*IW-1:IW] == '0, "row does not start at column zero")

endmodule

bind dense_matrix_row_multiply dmrm_checker u_dmrm_checker (.*);
